>>> design/base128_text_codec_top_defines.svh
// Assertion macros for the base128 text codec
`ifndef BASE128_TEXT_CODEC_TOP_DEFINES_SVH
`define BASE128_TEXT_CODEC_TOP_DEFINES_SVH

// checked only out of reset
`define B128_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define B128_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/b128_pkg.sv
// Shared types, constants and lookup functions for the base128 codec
`default_nettype none
package b128_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int SYM_W  = 7;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 3;

  localparam logic [POS_W-1:0] ENC_LAST_POS = 3'd6;

  localparam int ADDR_W = 3;
  localparam logic REG_MODE = 1'b0;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] ALPHABET [128] = '{
    8'h21, 8'h23, 8'h24, 8'h25, 8'h28, 8'h29, 8'h2A, 8'h2C, 8'h2E,
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
    8'h3A, 8'h3B, 8'h3D, 8'h40,
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
    8'h4D,
    8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h5A,
    8'h5B, 8'h5D, 8'h5E, 8'h5F,
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h6B, 8'h6C,
    8'h6D,
    8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79,
    8'h7A,
    8'h7B, 8'h7C, 8'h7D, 8'h7E,
    8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA, 8'hAB, 8'hAC,
    8'hAE, 8'hAF, 8'hB0, 8'hB1, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB8, 8'hB9,
    8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'hBE, 8'hBF, 8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5,
    8'hC6, 8'hC7, 8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC, 8'hCD, 8'hCE
  };

  typedef struct packed {
    logic hit;
    logic [SYM_W-1:0] idx;
  } sym_lookup_t;

  typedef struct packed {
    logic en;
    logic mode;
  } cfg_wr_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  // up to two results caused by one input item
  typedef struct packed {
    logic two;
    logic [BYTE_W-1:0] byte0;
    logic last0;
    logic [BYTE_W-1:0] byte1;
    logic last1;
  } job_t;

  // inverse alphabet: last matching entry wins
  function automatic sym_lookup_t symbol_index(input logic [BYTE_W-1:0] c);
    sym_lookup_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = 0; i < 128; i++) begin
      if (ALPHABET[i] == c) begin
        r.hit = 1'b1;
        r.idx = SYM_W'(i);
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> design/b128_stream_if.sv
// Valid/ready stream interfaces for codec input and result items
`default_nettype none
interface b128_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in;
  modport source (output valid, output data_byte, output last_in, input ready);
  modport sink (input valid, input data_byte, input last_in, output ready);
endinterface

interface b128_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;
  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink (input valid, input out_byte, input last_out, output ready);
endinterface
`default_nettype wire

>>> design/base128_text_codec_top.sv
// Top level of the streaming base128 codec with APB configuration
//
//   channel        dir   payload              handshake
//   byte_stream    in    data_byte, last_in   valid/ready
//   result_stream  out   out_byte, last_out   valid/ready
//   apb            in    mode (reg 0)         psel/penable, pready tied high
//
// One input item per cycle unless the job queue is full.
// Encoding yields 8 results per 7 bytes, so the output stage sets the rate:
// the four-entry job queue fills and then holds off the input.
// Synchronous reset clears state and queue; a mode write clears the group state.
// Output stalls back up through the queue to the input ready.
`default_nettype none
`include "base128_text_codec_top_defines.svh"
module base128_text_codec_top (
  input  logic                        clk,
  input  logic                        rst,
  b128_in_if.sink                     byte_stream,
  b128_out_if.source                  result_stream,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [b128_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import b128_pkg::*;

  cfg_wr_t   cfg_wr;
  logic      mode;
  logic      push;
  job_t      push_job;
  job_t      head_job;
  logic      pop;
  q_status_t q_stat;

  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite && pready && (paddr[2] == REG_MODE);
  assign cfg_wr.mode = pwdata[0];
  assign prdata      = (paddr[2] == REG_MODE) ? {31'd0, mode} : 32'd0;

  b128_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .mode     (mode),
    .in_valid (byte_stream.valid),
    .in_data  (byte_stream.data_byte),
    .in_last  (byte_stream.last_in),
    .in_ready (byte_stream.ready),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  b128_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  b128_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head_job  (head_job),
    .pop       (pop),
    .out_valid (result_stream.valid),
    .out_ready (result_stream.ready),
    .out_byte  (result_stream.out_byte),
    .out_last  (result_stream.last_out)
  );

  `B128_ASSERT(a_no_push_full, push |-> !q_stat.full, "job pushed into full queue")
  `B128_ASSERT(a_no_pop_empty, pop |-> q_stat.valid, "job popped from empty queue")
  `B128_ASSERT_ALWAYS(a_rst_empty, rst |=> !q_stat.valid && !result_stream.valid, "busy after reset")

endmodule
`default_nettype wire

>>> design/b128_front.sv
// Front end: accepts items, holds codec state, builds result jobs
`default_nettype none
module b128_front (
  input  logic                clk,
  input  logic                rst,
  input  b128_pkg::cfg_wr_t   cfg_wr,
  output logic                mode,
  input  logic                in_valid,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  output logic                in_ready,
  input  b128_pkg::q_status_t q_stat,
  output logic                push,
  output b128_pkg::job_t      push_job
);
  import b128_pkg::*;

  logic [POS_W-1:0]  pos;
  logic [SYM_W-1:0]  carry;
  logic [SYM_W-1:0]  prev;

  logic              accept;
  logic [POS_W-1:0]  enc_pos;
  logic [14:0]       enc_shl;
  logic [SYM_W-1:0]  enc_sym;
  logic [BYTE_W-1:0] enc_rem;
  logic [SYM_W-1:0]  enc_carry;
  logic              enc_two;
  sym_lookup_t       look;
  logic [SYM_W-1:0]  dec_sym;
  logic [14:0]       dec_shl;
  logic [BYTE_W-1:0] dec_byte;
  logic [SYM_W-1:0]  dec_rem;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    enc_pos   = (pos >= ENC_LAST_POS) ? ENC_LAST_POS : pos;
    enc_shl   = {7'd0, in_data} << enc_pos;
    enc_sym   = enc_shl[SYM_W-1:0] | carry;
    enc_rem   = in_data >> (3'd7 - enc_pos);
    enc_carry = enc_rem[SYM_W-1:0];
    enc_two   = (enc_pos == ENC_LAST_POS) || in_last;

    look      = symbol_index(in_data);
    dec_sym   = look.hit ? look.idx : prev;
    dec_shl   = {8'd0, dec_sym} << (4'd8 - {1'b0, pos});
    dec_byte  = dec_shl[BYTE_W-1:0] | {1'b0, carry};
    dec_rem   = dec_sym >> pos;
  end

  always_comb begin
    push = accept && ((mode == MODE_ENCODE) || (pos != '0));
    if (mode == MODE_ENCODE) begin
      push_job.two   = enc_two;
      push_job.byte0 = ALPHABET[enc_sym];
      push_job.last0 = 1'b0;
      push_job.byte1 = ALPHABET[enc_carry];
      push_job.last1 = in_last;
    end else begin
      push_job.two   = 1'b0;
      push_job.byte0 = dec_byte;
      push_job.last0 = in_last;
      push_job.byte1 = dec_byte;
      push_job.last1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_ENCODE;
      pos   <= '0;
      carry <= '0;
      prev  <= '0;
    end else if (cfg_wr.en) begin
      mode  <= cfg_wr.mode;
      pos   <= '0;
      carry <= '0;
      prev  <= '0;
    end else if (accept) begin
      if (in_last) begin
        pos   <= '0;
        carry <= '0;
        prev  <= '0;
      end else if (mode == MODE_ENCODE) begin
        if (enc_two) begin
          pos   <= '0;
          carry <= '0;
        end else begin
          pos   <= enc_pos + 3'd1;
          carry <= enc_carry;
        end
      end else begin
        if (look.hit) begin
          prev <= look.idx;
        end
        if (pos == '0) begin
          carry <= dec_sym;
          pos   <= 3'd1;
        end else begin
          carry <= dec_rem;
          pos   <= pos + 3'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/b128_queue.sv
// Short job queue between front end and output stage
`default_nettype none
module b128_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b128_pkg::job_t      push_job,
  input  logic                pop,
  output b128_pkg::job_t      head_job,
  output b128_pkg::q_status_t q_stat
);
  import b128_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.valid = (count != '0);
  assign head_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/b128_back.sv
// Output stage: sends one or two results per job through an output register
`default_nettype none
module b128_back (
  input  logic                clk,
  input  logic                rst,
  input  b128_pkg::q_status_t q_stat,
  input  b128_pkg::job_t      head_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import b128_pkg::*;

  logic second;
  logic load;

  assign load = q_stat.valid && (!out_valid || out_ready);
  assign pop  = load && (!head_job.two || second);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      second    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        second    <= !pop;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= second ? head_job.byte1 : head_job.byte0;
      out_last <= second ? head_job.last1 : head_job.last0;
    end
  end

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench for the streaming base128 text codec
module tb_top;
  import b128_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_AT        = 1300;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 330;
  localparam int N_PHASES       = 6;
  localparam logic [ADDR_W-1:0] MODE_ADDR  = ADDR_W'(4 * REG_MODE);
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_out;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  b128_in_if  byte_if ();
  b128_out_if res_if ();

  base128_text_codec_top u_top (
    .clk           (clk),
    .rst           (rst),
    .byte_stream   (byte_if),
    .result_stream (res_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // predictor state
  logic        cur_mode = MODE_ENCODE;
  int unsigned grp_pos = 0;
  logic [6:0]  carry = '0;
  logic [6:0]  prev_sym = '0;
  logic        inv_hit [256];
  logic [6:0]  inv_idx [256];

  byte_item_t tx_bytes[$];
  result_t    expected_results[$];
  byte_item_t next_item;
  result_t    got_exp;

  int items_pushed = 0;
  int n_accepted = 0;
  int n_predicted = 0;
  int n_checked = 0;
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  int quiet_cycles = 0;
  int n_pred_now;

  function automatic void clear_group_state();
    grp_pos  = 0;
    carry    = '0;
    prev_sym = '0;
  endfunction

  function automatic void report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", msg);
  endfunction

  // expected results of one accepted byte; returns how many
  function automatic int codec_predict(input logic [7:0] b, input logic last);
    int unsigned p;
    int unsigned bi;
    int unsigned si;
    logic [6:0] sym;
    result_t r [2];
    int n;
    bi = b;
    n = 0;
    p = grp_pos;
    if (cur_mode == MODE_ENCODE) begin
      if (p > ENC_LAST_POS) p = ENC_LAST_POS;
      sym = 7'(bi << p) | carry;
      carry = 7'(bi >> (7 - p));
      r[0] = '{ALPHABET[sym], 1'b0};
      n = 1;
      if (p == ENC_LAST_POS || last) begin
        r[1] = '{ALPHABET[carry], 1'b0};
        n = 2;
        carry = '0;
        grp_pos = 0;
      end else begin
        grp_pos = p + 1;
      end
      if (last) begin
        r[n-1].last_out = 1'b1;
        clear_group_state();
      end
    end else begin
      // bytes outside the alphabet reuse the previous symbol
      if (inv_hit[b]) prev_sym = inv_idx[b];
      si = prev_sym;
      if (p == 0) begin
        carry = 7'(si);
        grp_pos = 1;
      end else begin
        r[0] = '{8'(si << (8 - p)) | {1'b0, carry}, last};
        n = 1;
        carry = 7'(si >> p);
        grp_pos = (p + 1) % 8;
      end
      if (last) clear_group_state();
    end
    for (int i = 0; i < n; i++) expected_results.push_back(r[i]);
    return n;
  endfunction

  function automatic void push_byte(input logic [7:0] data, input logic last);
    tx_bytes.push_back('{data, last});
    items_pushed++;
  endfunction

  // random messages; the final one may be cut short and left open
  function automatic void queue_random_phase(input logic dec, input int n_items);
    int left;
    int len;
    logic [7:0] b;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
      for (int k = 0; k < len && left > 0; k++) begin
        if (dec && $urandom_range(99) >= 8) b = ALPHABET[$urandom_range(127)];
        else if ($urandom_range(19) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
        else b = 8'($urandom);
        push_byte(b, k == len - 1);
        left--;
      end
    end
  endfunction

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_mode_readback();
    logic [31:0] rd;
    apb_access(1'b0, MODE_ADDR, 32'h0, rd);
    if (rd[0] !== cur_mode)
      report_mismatch($sformatf("mode readback exp %0b got %0b", cur_mode, rd[0]));
  endtask

  task automatic set_mode(input logic m);
    logic [31:0] rd;
    apb_access(1'b1, MODE_ADDR, {31'h0, m}, rd);
    cur_mode = m;
    clear_group_state();
    check_mode_readback();
  endtask

  task automatic wait_drain();
    while (n_accepted != items_pushed || n_predicted != n_checked) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      byte_if.valid     <= 1'b0;
      byte_if.data_byte <= '0;
      byte_if.last_in   <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        n_pred_now = codec_predict(byte_if.data_byte, byte_if.last_in);
        n_predicted <= n_predicted + n_pred_now;
        n_accepted  <= n_accepted + 1;
      end
      if (!byte_if.valid || byte_if.ready) begin
        if (tx_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          next_item = tx_bytes.pop_front();
          byte_if.valid     <= 1'b1;
          byte_if.data_byte <= next_item.data;
          byte_if.last_in   <= next_item.last;
        end else begin
          byte_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h last %0b",
                                    res_if.out_byte, res_if.last_out));
        end else begin
          got_exp = expected_results.pop_front();
          if (got_exp.out_byte !== res_if.out_byte || got_exp.last_out !== res_if.last_out)
            report_mismatch($sformatf("result %0d exp byte %02h last %0b got byte %02h last %0b",
                                      n_checked, got_exp.out_byte, got_exp.last_out,
                                      res_if.out_byte, res_if.last_out));
          n_checked <= n_checked + 1;
        end
      end
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done    <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((byte_if.valid && byte_if.ready) || (res_if.valid && res_if.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", quiet_cycles);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] rd;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_in   = 1'b0;
    res_if.ready      = 1'b0;
    for (int i = 0; i < 256; i++) begin
      inv_hit[i] = 1'b0;
      inv_idx[i] = '0;
    end
    for (int i = 0; i < 128; i++) begin
      inv_hit[ALPHABET[i]] = 1'b1;
      inv_idx[ALPHABET[i]] = 7'(i);
    end
    tx_idle_pct  = 10;
    rx_stall_pct = 57;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    check_mode_readback();
    set_mode(MODE_ENCODE);
    // full group ending on a two-symbol byte, then a flush after one byte
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hFE, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h3C, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h0F, 1'b0);
    push_byte(8'hF0, 1'b1);
    wait_drain();

    set_mode(MODE_DECODE);
    // non-alphabet bytes right after the mode write fall back to symbol 0
    push_byte(8'h00, 1'b0);
    push_byte(8'hA0, 1'b1);
    // message that ends on a carry-only symbol
    push_byte(8'h21, 1'b1);
    push_byte(8'hCE, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h22, 1'b0);
    push_byte(8'h21, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'hA1, 1'b0);
    push_byte(8'hCE, 1'b0);
    push_byte(8'h21, 1'b1);
    wait_drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct  = 10;
          rx_stall_pct = 57;
        end
        1: begin
          tx_idle_pct  = 57;
          rx_stall_pct = 10;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      set_mode((ph % 2) ? MODE_DECODE : MODE_ENCODE);
      if (ph == 3) begin
        // unmapped register: write is dropped, mode and group state stay
        apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FFFF, rd);
        check_mode_readback();
      end
      queue_random_phase(ph % 2, PHASE_ITEMS);
      wait_drain();
    end

    $display("Run covered %0d input items over encode and decode with three idle profiles,",
             n_accepted);
    $display("a long output hold and %0d checked results; %0d mismatches.",
             n_checked, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
